// ----- rtl/core/gbs_pkg.sv -----
package gbs_pkg;

  localparam int unsigned GBS_MAX_BOXES = 64;
  // most results one set can return
  localparam logic [6:0]  RESULT_CAP    = 7'd64;

  localparam logic [8:0]  IOU_THR_RST   = 9'd77;
  localparam logic [6:0]  MAX_RES_RST   = 7'd10;

  localparam logic [1:0]  CFG_IOU_THR   = 2'd0;
  localparam logic [1:0]  CFG_MAX_RES   = 2'd1;

  // last eval count, at which the cells apply the overlap result
  localparam logic [1:0]  EVAL_LAST     = 2'd3;

  typedef struct packed {
    logic [15:0]        score;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [12:0]        w;
    logic [12:0]        h;
    logic [15:0]        tag;
  } box_t;

  typedef struct packed {
    logic valid;
    logic supp;
    box_t box;
  } slot_t;

  typedef struct packed {
    logic clr;
    logic ins;
    logic shl;
    logic upd;
  } ctrl_t;

endpackage

// ----- rtl/core/gbs_iou.sv -----
module gbs_iou (
  input  logic             clk_i,
  input  gbs_pkg::box_t    a_i,
  input  gbs_pkg::box_t    b_i,
  input  logic [8:0]       thr_i,
  output logic             exceed_o
);

  logic signed [17:0] ax, bx, ay, by, ax2, bx2, ay2, by2;
  logic signed [17:0] x1, x2, y1, y2, ddx, ddy;

  logic [12:0] dx_q, dy_q, aw_q, ah_q, bw_q, bh_q;
  logic        ov_q;
  logic [25:0] inter_d, aa_d, ab_d, inter_q, aa_q, ab_q, inter2_q;
  logic [26:0] uni;
  logic [35:0] prod_d, prod_q;

  assign ax  = {{2{a_i.x[15]}}, a_i.x};
  assign bx  = {{2{b_i.x[15]}}, b_i.x};
  assign ay  = {{2{a_i.y[15]}}, a_i.y};
  assign by  = {{2{b_i.y[15]}}, b_i.y};
  assign ax2 = ax + $signed({5'b0, a_i.w});
  assign bx2 = bx + $signed({5'b0, b_i.w});
  assign ay2 = ay + $signed({5'b0, a_i.h});
  assign by2 = by + $signed({5'b0, b_i.h});
  assign x1  = (ax > bx) ? ax : bx;
  assign y1  = (ay > by) ? ay : by;
  assign x2  = (ax2 < bx2) ? ax2 : bx2;
  assign y2  = (ay2 < by2) ? ay2 : by2;
  assign ddx = x2 - x1;
  assign ddy = y2 - y1;

  assign inter_d = ov_q ? ({13'b0, dx_q} * {13'b0, dy_q}) : 26'd0;
  assign aa_d    = {13'b0, aw_q} * {13'b0, ah_q};
  assign ab_d    = {13'b0, bw_q} * {13'b0, bh_q};
  assign uni     = {1'b0, aa_q} + {1'b0, ab_q} - {1'b0, inter_q};
  assign prod_d  = {27'b0, thr_i} * {9'b0, uni};

  always_ff @(posedge clk_i) begin
    dx_q     <= ddx[12:0];
    dy_q     <= ddy[12:0];
    ov_q     <= !ddx[17] && !ddy[17];
    aw_q     <= a_i.w;
    ah_q     <= a_i.h;
    bw_q     <= b_i.w;
    bh_q     <= b_i.h;
    inter_q  <= inter_d;
    aa_q     <= aa_d;
    ab_q     <= ab_d;
    inter2_q <= inter_q;
    prod_q   <= prod_d;
  end

  assign exceed_o = {2'b0, inter2_q, 8'b0} > prod_q;

endmodule

// ----- rtl/core/gbs_cell.sv -----
module gbs_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  gbs_pkg::ctrl_t  ctrl_i,
  input  gbs_pkg::box_t   new_i,
  input  gbs_pkg::box_t   head_i,
  input  logic [8:0]      thr_i,
  input  gbs_pkg::slot_t  left_i,
  input  logic            left_cond_i,
  input  gbs_pkg::slot_t  right_i,
  output gbs_pkg::slot_t  slot_o,
  output logic            cond_o
);

  logic          valid_q, supp_q, exceed;
  gbs_pkg::box_t box_q;

  // insert point lies here or further left
  assign cond_o = !valid_q || (box_q.score < new_i.score);

  gbs_iou u_iou (
    .clk_i    (clk_i),
    .a_i      (head_i),
    .b_i      (box_q),
    .thr_i    (thr_i),
    .exceed_o (exceed)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      supp_q  <= 1'b0;
    end else if (ctrl_i.clr) begin
      valid_q <= 1'b0;
      supp_q  <= 1'b0;
    end else if (ctrl_i.ins) begin
      if (cond_o) begin
        // take the neighbor's slot when shifting, else the new box
        valid_q <= left_cond_i ? left_i.valid : 1'b1;
        supp_q  <= 1'b0;
      end
    end else if (ctrl_i.shl) begin
      valid_q <= right_i.valid;
      supp_q  <= right_i.supp;
    end else if (ctrl_i.upd) begin
      if (valid_q && exceed) begin
        supp_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ins && cond_o) begin
      box_q <= left_cond_i ? left_i.box : new_i;
    end else if (!ctrl_i.ins && ctrl_i.shl) begin
      box_q <= right_i.box;
    end
  end

  assign slot_o = '{valid: valid_q, supp: supp_q, box: box_q};

endmodule

// ----- rtl/core/greedy_box_suppression.sv -----
// Greedy box suppression by intersection-over-union.
//
// Load a set: pulse start with one box per beat while busy is low; a beat is
// taken at each edge with start high and busy low. Each box slides into a
// score-ordered chain of cells (descending score, equal scores in arrival
// order) as its beat is taken. The beat with final_box_i set closes the set
// and raises busy. Boxes past MAX_BOXES are dropped and flag overflowed_o on
// every result of that set.
// Walk: the head cell is examined once per cycle while walking, not while a
// kept head is evaluated. A suppressed head is dropped by a left shift. A kept
// head is latched and every cell compares it against its own box in a
// three-stage overlap pipeline.
// Results: one beat per kept box on kept_valid_o, held one cycle only, with
// last_kept_o on the final one. An empty keep set gives a single beat with
// empty_set_o. The receiver cannot stall. busy drops with the last beat.
// Configuration: cfg_ready_o is always high; write while the block is idle.
// Reset clears the chain, counters and registers to their reset values.
module greedy_box_suppression #(
  parameter int unsigned MAX_BOXES = gbs_pkg::GBS_MAX_BOXES
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [15:0]         score_i,
  input  logic signed [15:0]  box_x_i,
  input  logic signed [15:0]  box_y_i,
  input  logic [12:0]         box_width_i,
  input  logic [12:0]         box_height_i,
  input  logic [15:0]         tag_i,
  input  logic                final_box_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [8:0]          cfg_data_i,
  output logic                kept_valid_o,
  output logic [15:0]         kept_tag_o,
  output logic [15:0]         kept_score_o,
  output logic signed [15:0]  kept_x_o,
  output logic signed [15:0]  kept_y_o,
  output logic [12:0]         kept_width_o,
  output logic [12:0]         kept_height_o,
  output logic                empty_set_o,
  output logic                overflowed_o,
  output logic                last_kept_o
);

  localparam int unsigned CW = $clog2(MAX_BOXES + 1);

  typedef enum logic [1:0] {S_LOAD, S_WALK, S_EVAL} state_e;

  state_e         state_q;
  logic [CW-1:0]  count_q;
  logic           ovf_q;
  logic [6:0]     kept_q;
  logic [1:0]     ecnt_q;
  logic [8:0]     thr_q;
  logic [6:0]     maxres_q;
  logic [6:0]     limit;
  logic           pend_v_q;
  gbs_pkg::box_t  pend_q, hd_q, new_box;
  gbs_pkg::ctrl_t ctrl;
  gbs_pkg::slot_t slot [MAX_BOXES];
  logic           cond [MAX_BOXES];
  logic           accept, full, walk_done;

  logic          out_v_q, out_empty_q, out_ovf_q, out_last_q;
  gbs_pkg::box_t out_q;

  assign busy        = (state_q != S_LOAD);
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;
  assign full        = (count_q == CW'(MAX_BOXES));
  assign limit       = (maxres_q > gbs_pkg::RESULT_CAP) ? gbs_pkg::RESULT_CAP : maxres_q;
  assign walk_done   = !slot[0].valid || (kept_q == limit);

  assign new_box = '{score: score_i, x: box_x_i, y: box_y_i,
                     w: box_width_i, h: box_height_i, tag: tag_i};

  always_comb begin
    ctrl.ins = accept && !full;
    ctrl.shl = (state_q == S_WALK) && !walk_done;
    ctrl.clr = (state_q == S_WALK) && walk_done;
    ctrl.upd = (state_q == S_EVAL) && (ecnt_q == gbs_pkg::EVAL_LAST);
  end

  // the chain: cell 0 is the head, data moves right on insert, left on walk
  for (genvar g = 0; g < MAX_BOXES; g++) begin : g_cell
    gbs_pkg::slot_t left_s, right_s;
    logic           left_c;
    if (g == 0) begin : g_first
      assign left_s = '0;
      assign left_c = 1'b0;
    end else begin : g_mid
      assign left_s = slot[g-1];
      assign left_c = cond[g-1];
    end
    if (g == MAX_BOXES - 1) begin : g_last
      assign right_s = '0;
    end else begin : g_inner
      assign right_s = slot[g+1];
    end
    gbs_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .new_i       (new_box),
      .head_i      (hd_q),
      .thr_i       (thr_q),
      .left_i      (left_s),
      .left_cond_i (left_c),
      .right_i     (right_s),
      .slot_o      (slot[g]),
      .cond_o      (cond[g])
    );
  end

  // payload registers: head under test, pending result, result beat
  always_ff @(posedge clk_i) begin
    if (ctrl.shl && !slot[0].supp) begin
      hd_q   <= slot[0].box;
      pend_q <= slot[0].box;
    end
    if (ctrl.clr) begin
      out_q       <= pend_v_q ? pend_q : '0;
      out_empty_q <= !pend_v_q;
      out_ovf_q   <= ovf_q;
      out_last_q  <= 1'b1;
    end else if (ctrl.shl && !slot[0].supp) begin
      out_q       <= pend_q;
      out_empty_q <= 1'b0;
      out_ovf_q   <= ovf_q;
      out_last_q  <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_LOAD;
      count_q  <= '0;
      ovf_q    <= 1'b0;
      kept_q   <= '0;
      ecnt_q   <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      thr_q    <= gbs_pkg::IOU_THR_RST;
      maxres_q <= gbs_pkg::MAX_RES_RST;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          gbs_pkg::CFG_IOU_THR: thr_q    <= cfg_data_i;
          gbs_pkg::CFG_MAX_RES: maxres_q <= cfg_data_i[6:0];
          default: ;
        endcase
      end
      case (state_q)
        S_LOAD: begin
          out_v_q <= 1'b0;
          if (accept) begin
            if (full) begin
              ovf_q <= 1'b1;
            end else begin
              count_q <= count_q + 1'b1;
            end
            if (final_box_i) begin
              state_q <= S_WALK;
            end
          end
        end
        S_WALK: begin
          if (walk_done) begin
            // flush the pending result as last, or an empty marker
            out_v_q  <= 1'b1;
            count_q  <= '0;
            ovf_q    <= 1'b0;
            kept_q   <= '0;
            pend_v_q <= 1'b0;
            state_q  <= S_LOAD;
          end else if (!slot[0].supp) begin
            out_v_q  <= pend_v_q;
            pend_v_q <= 1'b1;
            kept_q   <= kept_q + 1'b1;
            ecnt_q   <= '0;
            state_q  <= S_EVAL;
          end else begin
            out_v_q  <= 1'b0;
          end
        end
        S_EVAL: begin
          out_v_q <= 1'b0;
          ecnt_q  <= ecnt_q + 1'b1;
          if (ecnt_q == gbs_pkg::EVAL_LAST) begin
            state_q <= S_WALK;
          end
        end
        default: begin
          out_v_q <= 1'b0;
          state_q <= S_LOAD;
        end
      endcase
    end
  end

  assign kept_valid_o  = out_v_q;
  assign kept_tag_o    = out_q.tag;
  assign kept_score_o  = out_q.score;
  assign kept_x_o      = out_q.x;
  assign kept_y_o      = out_q.y;
  assign kept_width_o  = out_q.w;
  assign kept_height_o = out_q.h;
  assign empty_set_o   = out_empty_q;
  assign overflowed_o  = out_ovf_q;
  assign last_kept_o   = out_last_q;

`ifndef SYNTHESIS
  a_beat_from_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_valid_o |-> $past(state_q == S_WALK))
    else $error("result beat not issued from the walk");
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (kept_valid_o && empty_set_o) |-> last_kept_o)
    else $error("empty marker without last flag");
  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (kept_valid_o && last_kept_o) |-> !busy)
    else $error("busy after last result");
  a_kept_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_q <= limit)
    else $error("kept count beyond limit");
`endif

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

  // One box beat as the driver presents it.
  typedef struct {
    logic [15:0]        score;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [12:0]        w;
    logic [12:0]        h;
    logic [15:0]        tag;
    logic               fin;
  } box_beat_t;

  // One kept-box beat as the block should report it.
  typedef struct {
    logic [15:0]        tag;
    logic [15:0]        score;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [12:0]        w;
    logic [12:0]        h;
    logic               empty;
    logic               ovf;
    logic               last;
  } kept_beat_t;

  localparam int WATCHDOG_LIMIT = 6000;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [15:0]        score_i;
  logic signed [15:0] box_x_i;
  logic signed [15:0] box_y_i;
  logic [12:0]        box_width_i;
  logic [12:0]        box_height_i;
  logic [15:0]        tag_i;
  logic               final_box_i;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i;
  logic [8:0]         cfg_data_i;
  logic               kept_valid_o;
  logic [15:0]        kept_tag_o;
  logic [15:0]        kept_score_o;
  logic signed [15:0] kept_x_o;
  logic signed [15:0] kept_y_o;
  logic [12:0]        kept_width_o;
  logic [12:0]        kept_height_o;
  logic               empty_set_o;
  logic               overflowed_o;
  logic               last_kept_o;

  greedy_box_suppression u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .score_i      (score_i),
    .box_x_i      (box_x_i),
    .box_y_i      (box_y_i),
    .box_width_i  (box_width_i),
    .box_height_i (box_height_i),
    .tag_i        (tag_i),
    .final_box_i  (final_box_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .kept_valid_o (kept_valid_o),
    .kept_tag_o   (kept_tag_o),
    .kept_score_o (kept_score_o),
    .kept_x_o     (kept_x_o),
    .kept_y_o     (kept_y_o),
    .kept_width_o (kept_width_o),
    .kept_height_o(kept_height_o),
    .empty_set_o  (empty_set_o),
    .overflowed_o (overflowed_o),
    .last_kept_o  (last_kept_o)
  );

  // Boxes waiting for the driver, and kept boxes waiting for the block.
  box_beat_t  box_queue[$];
  kept_beat_t kept_queue[$];

  // Shadow of the block: current set and register copies.
  box_beat_t  set_boxes[gbs_pkg::GBS_MAX_BOXES];
  int         set_fill;
  logic       set_overflow;
  logic [8:0] shadow_thr;
  logic [6:0] shadow_max;

  int  error_count;
  int  boxes_sent;
  int  sets_closed;
  int  kept_checked;
  int  empty_checked;
  int  overflow_sets;
  int  idle_cycles;
  int  gap_left;

  // Idle mode: 0 back to back, 1 mixed gaps.
  int  gap_mode;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Exact overlap test: inter*256 > thr*union, all in 64-bit integers.
  function automatic bit overlap_exceeds(box_beat_t a, box_beat_t b, logic [8:0] thr);
    longint ax, ay, aw, ah, bx, by, bw, bh;
    longint x1, y1, x2, y2, inter, uni;
    ax = a.x; ay = a.y; aw = a.w; ah = a.h;
    bx = b.x; by = b.y; bw = b.w; bh = b.h;
    x1 = (ax > bx) ? ax : bx;
    y1 = (ay > by) ? ay : by;
    x2 = (ax + aw < bx + bw) ? ax + aw : bx + bw;
    y2 = (ay + ah < by + bh) ? ay + ah : by + bh;
    inter = 0;
    if (x2 >= x1 && y2 >= y1) inter = (x2 - x1) * (y2 - y1);
    uni = aw * ah + bw * bh - inter;
    return inter * 256 > longint'(thr) * uni;
  endfunction

  // Absorb one accepted box; on a closing beat sort, walk and queue kept boxes.
  task automatic absorb_box(box_beat_t b);
    int order[gbs_pkg::GBS_MAX_BOXES];
    bit supp[gbs_pkg::GBS_MAX_BOXES];
    int kept_idx[$];
    int limit, j, cur;
    kept_beat_t r;
    if (set_fill < gbs_pkg::GBS_MAX_BOXES) begin
      set_boxes[set_fill] = b;
      set_fill++;
    end else begin
      set_overflow = 1'b1;
    end
    if (!b.fin) return;
    // stable sort, descending score
    for (int i = 0; i < set_fill; i++) begin
      j = i;
      cur = i;
      while (j > 0 && set_boxes[order[j-1]].score < set_boxes[cur].score) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = cur;
      supp[i] = 1'b0;
    end
    limit = (shadow_max > gbs_pkg::RESULT_CAP) ? gbs_pkg::RESULT_CAP : shadow_max;
    for (int i = 0; i < set_fill && kept_idx.size() < limit; i++) begin
      if (supp[i]) continue;
      kept_idx.insert(kept_idx.size(), order[i]);
      for (int k = i + 1; k < set_fill; k++)
        if (!supp[k] && overlap_exceeds(set_boxes[order[i]], set_boxes[order[k]], shadow_thr))
          supp[k] = 1'b1;
    end
    if (kept_idx.size() == 0) begin
      r = '{tag: '0, score: '0, x: '0, y: '0, w: '0, h: '0,
            empty: 1'b1, ovf: set_overflow, last: 1'b1};
      kept_queue.insert(kept_queue.size(), r);
    end else begin
      foreach (kept_idx[k]) begin
        r.tag   = set_boxes[kept_idx[k]].tag;
        r.score = set_boxes[kept_idx[k]].score;
        r.x     = set_boxes[kept_idx[k]].x;
        r.y     = set_boxes[kept_idx[k]].y;
        r.w     = set_boxes[kept_idx[k]].w;
        r.h     = set_boxes[kept_idx[k]].h;
        r.empty = 1'b0;
        r.ovf   = set_overflow;
        r.last  = (k == kept_idx.size() - 1);
        kept_queue.insert(kept_queue.size(), r);
      end
    end
    if (set_overflow) overflow_sets++;
    sets_closed++;
    set_fill = 0;
    set_overflow = 1'b0;
  endtask

  // Hand out the next gap length: mostly short, now and then long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (gap_mode == 0) return 0;
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver: advance on the falling edge, hold a beat until it is taken.
  logic took_beat;
  always @(negedge clk_i) begin
    box_beat_t b;
    logic      next_start;
    next_start = start;
    if (rst_ni && (!start || took_beat)) begin
      next_start = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (box_queue.size() > 0) begin
        b = box_queue.pop_front();
        score_i      <= b.score;
        box_x_i      <= b.x;
        box_y_i      <= b.y;
        box_width_i  <= b.w;
        box_height_i <= b.h;
        tag_i        <= b.tag;
        final_box_i  <= b.fin;
        next_start   = 1'b1;
        gap_left     = pick_gap();
      end
    end
    start <= next_start;
  end

  // Monitor: sample on the rising edge, predict on each box beat and check
  // each kept beat against the oldest expectation.
  always @(posedge clk_i) begin
    box_beat_t  b;
    kept_beat_t e;
    logic       took;
    logic       active;
    took   = 1'b0;
    active = 1'b0;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        active = 1'b1;
        if (cfg_index_i == gbs_pkg::CFG_IOU_THR) shadow_thr = cfg_data_i;
        else if (cfg_index_i == gbs_pkg::CFG_MAX_RES) shadow_max = cfg_data_i[6:0];
      end
      if (start && !busy) begin
        b = '{score: score_i, x: box_x_i, y: box_y_i, w: box_width_i,
              h: box_height_i, tag: tag_i, fin: final_box_i};
        took   = 1'b1;
        active = 1'b1;
        boxes_sent++;
        absorb_box(b);
      end
      if (kept_valid_o) begin
        active = 1'b1;
        if (kept_queue.size() == 0) begin
          $error("kept beat with nothing expected: tag %0h", kept_tag_o);
          error_count++;
        end else begin
          e = kept_queue.pop_front();
          if (e.empty) empty_checked++; else kept_checked++;
          if (kept_tag_o !== e.tag) begin
            $error("kept_tag: expected %0h, got %0h", e.tag, kept_tag_o); error_count++;
          end
          if (kept_score_o !== e.score) begin
            $error("kept_score: expected %0h, got %0h", e.score, kept_score_o); error_count++;
          end
          if (kept_x_o !== e.x) begin
            $error("kept_x: expected %0d, got %0d", e.x, kept_x_o); error_count++;
          end
          if (kept_y_o !== e.y) begin
            $error("kept_y: expected %0d, got %0d", e.y, kept_y_o); error_count++;
          end
          if (kept_width_o !== e.w) begin
            $error("kept_width: expected %0d, got %0d", e.w, kept_width_o); error_count++;
          end
          if (kept_height_o !== e.h) begin
            $error("kept_height: expected %0d, got %0d", e.h, kept_height_o); error_count++;
          end
          if (empty_set_o !== e.empty) begin
            $error("empty_set: expected %0b, got %0b", e.empty, empty_set_o); error_count++;
          end
          if (overflowed_o !== e.ovf) begin
            $error("overflowed: expected %0b, got %0b", e.ovf, overflowed_o); error_count++;
          end
          if (last_kept_o !== e.last) begin
            $error("last_kept: expected %0b, got %0b", e.last, last_kept_o); error_count++;
          end
        end
      end
      idle_cycles <= active ? 0 : idle_cycles + 1;
    end
    took_beat <= took;
  end

  // Watchdog: no config write, box or kept beat for too long means the block is stuck.
  always @(posedge clk_i) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d kept beats outstanding", kept_queue.size());
      $display("tb_top failed");
      $finish;
    end
  end

  function automatic box_beat_t make_box(bit near, logic [15:0] tag_val, bit fin);
    box_beat_t b;
    int roll;
    roll = $urandom_range(0, 9);
    if (near) begin
      // clustered boxes so that overlaps and suppression really happen
      b.x = 16'($urandom_range(0, 240)) - 16'sd120;
      b.y = 16'($urandom_range(0, 240)) - 16'sd120;
      b.w = 13'($urandom_range(0, 200));
      b.h = 13'($urandom_range(0, 200));
    end else begin
      b.x = 16'($urandom);
      b.y = 16'($urandom);
      b.w = 13'($urandom);
      b.h = 13'($urandom);
    end
    // tied scores now and then to exercise arrival order
    b.score = (roll < 3) ? 16'($urandom_range(0, 3)) * 16'h4000 : 16'($urandom);
    if (roll == 9) b.score = 16'hFFFF;
    b.tag = tag_val;
    b.fin = fin;
    return b;
  endfunction

  task automatic queue_set(int count, bit near);
    for (int i = 0; i < count; i++)
      box_queue.insert(box_queue.size(),
                       make_box(near && ($urandom_range(0, 9) != 0),
                                16'($urandom), i == count - 1));
  endtask

  // Drain: all boxes taken, all kept beats seen, then settle before a write.
  task automatic drain_block();
    while (box_queue.size() > 0 || start) @(posedge clk_i);
    while (kept_queue.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [8:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_phase(int items);
    int sent;
    int count;
    sent = 0;
    gap_mode = $urandom_range(0, 3) != 0;
    while (sent < items) begin
      // mostly small sets, now and then one past capacity
      count = ($urandom_range(0, 19) == 0) ? $urandom_range(65, 70) : $urandom_range(1, 12);
      queue_set(count, 1'b1);
      sent += count;
    end
  endtask

  initial begin
    logic [8:0]  thr_list[6];
    logic [6:0]  max_list[6];
    start        = 1'b0;
    score_i      = '0;
    box_x_i      = '0;
    box_y_i      = '0;
    box_width_i  = '0;
    box_height_i = '0;
    tag_i        = '0;
    final_box_i  = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = gbs_pkg::CFG_IOU_THR;
    cfg_data_i   = '0;
    took_beat    = 1'b0;
    gap_left     = 0;
    gap_mode     = 1;
    error_count  = 0;
    boxes_sent   = 0;
    sets_closed  = 0;
    kept_checked = 0;
    empty_checked = 0;
    overflow_sets = 0;
    idle_cycles  = 0;
    set_fill     = 0;
    set_overflow = 1'b0;
    shadow_thr   = gbs_pkg::IOU_THR_RST;
    shadow_max   = gbs_pkg::MAX_RES_RST;
    rst_ni       = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed sets at reset settings (the second a single box): extremes, identical
    // boxes (suppressed), touching boxes (no overlap), zero-area boxes, tied scores.
    box_queue.insert(box_queue.size(),
      '{16'hFFFF, 16'sh8000, 16'sh8000, 13'h1FFF, 13'h1FFF, 16'h0000, 0});
    box_queue.insert(box_queue.size(),
      '{16'hFFFF, 16'sh7FFF, 16'sh7FFF, 13'h1FFF, 13'h1FFF, 16'hFFFF, 0});
    box_queue.insert(box_queue.size(),
      '{16'h0000, 16'sh0000, 16'sh0000, 13'd0, 13'd0, 16'h5555, 0});
    box_queue.insert(box_queue.size(),
      '{16'h0100, 16'sd10, 16'sd10, 13'd50, 13'd50, 16'hAAAA, 0});
    box_queue.insert(box_queue.size(),
      '{16'h0100, 16'sd10, 16'sd10, 13'd50, 13'd50, 16'h0001, 0});
    box_queue.insert(box_queue.size(),
      '{16'h0200, 16'sd60, 16'sd10, 13'd50, 13'd50, 16'h0002, 0});
    box_queue.insert(box_queue.size(),
      '{16'h0080, 16'sd15, 16'sd15, 13'd50, 13'd50, 16'h0003, 0});
    box_queue.insert(box_queue.size(),
      '{16'h0300, 16'sd10, 16'sd10, 13'd0, 13'd40, 16'h0004, 0});
    box_queue.insert(box_queue.size(),
      '{16'h0300, 16'sd10, 16'sd10, 13'd0, 13'd40, 16'h0005, 0});
    box_queue.insert(box_queue.size(),
      '{16'h8000, -16'sd5, -16'sd5, 13'd10, 13'd10, 16'h0006, 1});
    box_queue.insert(box_queue.size(),
      '{16'h1234, 16'sd1, 16'sd2, 13'd3, 13'd4, 16'h0007, 1});
    drain_block();

    thr_list = '{9'd0, 9'd256, 9'd128, 9'd511, 9'd40, 9'd77};
    max_list = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd3, 7'd10};
    foreach (thr_list[p]) begin
      write_reg(gbs_pkg::CFG_IOU_THR, thr_list[p]);
      write_reg(gbs_pkg::CFG_MAX_RES, {2'b00, max_list[p]});
      // max_results = 0: every set comes back empty, so keep that phase short
      random_phase(max_list[p] == 0 ? 30 : 70);
      drain_block();
    end

    $display("sent %0d boxes in %0d sets over 7 register settings (%0d with overflow)",
             boxes_sent, sets_closed, overflow_sets);
    $display("checked %0d kept beats and %0d empty-set beats", kept_checked, empty_checked);
    if (error_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
